FILE: hdl/hrv_pkg.sv
// Shared types and constants of the HTTP request validator.
// Classified byte item, result status codes, queue sizing. No dependencies.
package hrv_pkg;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int DIGIT_W  = 4;
   localparam int HEADER_W = 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_METHOD  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LITERAL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DIGIT   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DELIM   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_ILLEGAL = 3'd5;
   localparam logic [STATUS_W-1:0] ST_HOST    = 3'd6;

   // one request byte with its character class
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              legal;
      logic              digit;
      logic              space;
      logic              colon;
      logic              cr;
      logic              lf;
   } item_type;

endpackage

FILE: hdl/hrv_front.sv
// Front end: classifies each incoming request byte.
// Depends on hrv_pkg for item_type.
module hrv_front (
   input  logic [hrv_pkg::BYTE_W-1:0] in_byte,
   input  logic                       in_last,
   output hrv_pkg::item_type          item
);

   always_comb begin
      item.data  = in_byte;
      item.last  = in_last;
      item.legal = (in_byte >= 8'h21) && (in_byte <= 8'h7A);
      item.digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
      item.space = (in_byte == 8'h20);
      item.colon = (in_byte == 8'h3A);
      item.cr    = (in_byte == 8'h0D);
      item.lf    = (in_byte == 8'h0A);
   end

endmodule

FILE: hdl/hrv_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on hrv_pkg for item_type and queue sizing.
module hrv_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  hrv_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop,
   output hrv_pkg::item_type pop_item
);

   hrv_pkg::item_type                mem_ff [hrv_pkg::QUEUE_DEPTH];
   logic [hrv_pkg::QUEUE_AW-1:0]     wr_ptr_ff;
   logic [hrv_pkg::QUEUE_AW-1:0]     rd_ptr_ff;
   logic [hrv_pkg::QUEUE_CW-1:0]     count_ff;
   logic [hrv_pkg::QUEUE_CW-1:0]     count_in;
   logic                             do_push;
   logic                             do_pop;

   assign push_ready = (count_ff != hrv_pkg::QUEUE_CW'(hrv_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hdl/hrv_back.sv
// Back end: request-line and header parser state machine plus result register.
// Depends on hrv_pkg for item_type and status codes.
module hrv_back #(
   parameter int COUNT_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  hrv_pkg::item_type             item,
   output logic                          item_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hrv_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_method_post,
   output logic [hrv_pkg::DIGIT_W-1:0]   rsp_major_version,
   output logic [hrv_pkg::DIGIT_W-1:0]   rsp_minor_version,
   output logic                          rsp_host_present,
   output logic [hrv_pkg::HEADER_W-1:0]  rsp_header_count
);

   localparam int CNT_W = (COUNT_BITS < hrv_pkg::HEADER_W) ? COUNT_BITS : hrv_pkg::HEADER_W;

   localparam logic [3:0] PH_METHOD = 4'd0;
   localparam logic [3:0] PH_RES    = 4'd1;
   localparam logic [3:0] PH_HTTP   = 4'd2;
   localparam logic [3:0] PH_MAJ    = 4'd3;
   localparam logic [3:0] PH_DOT    = 4'd4;
   localparam logic [3:0] PH_MIN    = 4'd5;
   localparam logic [3:0] PH_CRLF   = 4'd6;
   localparam logic [3:0] PH_KEY    = 4'd7;
   localparam logic [3:0] PH_VAL    = 4'd8;

   localparam logic [2:0] HOST_HIT  = 3'd4;
   localparam logic [2:0] HOST_MISS = 3'd5;

   typedef struct packed {
      logic       ill;
      logic [2:0] hm;
   } field_type;

   function automatic logic [7:0] method_char(input logic post, input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case ({post, idx})
         4'b0_001: c = 8'h45; // E
         4'b0_010: c = 8'h54; // T
         4'b0_011: c = 8'h20;
         4'b1_001: c = 8'h4F; // O
         4'b1_010: c = 8'h53; // S
         4'b1_011: c = 8'h54; // T
         4'b1_100: c = 8'h20;
         default:  c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] http_char(input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case (idx)
         3'd0:    c = 8'h48; // H
         3'd1:    c = 8'h54; // T
         3'd2:    c = 8'h54; // T
         3'd3:    c = 8'h50; // P
         3'd4:    c = 8'h2F; // /
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] host_char(input logic [1:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case (idx)
         2'd0:    c = 8'h48; // H
         2'd1:    c = 8'h6F; // o
         2'd2:    c = 8'h73; // s
         2'd3:    c = 8'h74; // t
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // one key/value byte: illegal flag and Host key matcher
   function automatic field_type field_step(input field_type cur, input logic is_key,
                                            input logic [7:0] c, input logic legal);
      field_type nxt;
      nxt = cur;
      if (!legal) begin
         nxt.ill = 1'b1;
      end
      if (is_key) begin
         if (cur.hm < HOST_HIT && c == host_char(cur.hm[1:0])) begin
            nxt.hm = cur.hm + 3'd1;
         end else begin
            nxt.hm = HOST_MISS;
         end
      end
      return nxt;
   endfunction

   logic [3:0]                   phase_ff,   phase_in;
   logic [2:0]                   lit_idx_ff, lit_idx_in;
   logic                         method_ff,  method_in;
   logic [hrv_pkg::DIGIT_W-1:0]  major_ff,   major_in;
   logic [hrv_pkg::DIGIT_W-1:0]  minor_ff,   minor_in;
   logic                         dpend_ff,   dpend_in;
   logic                         illegal_ff, illegal_in;
   logic [2:0]                   hmatch_ff,  hmatch_in;
   logic                         host_ff,    host_in;
   logic [CNT_W-1:0]             lines_ff,   lines_in;
   logic [hrv_pkg::STATUS_W-1:0] err_ff,     err_in;
   logic [hrv_pkg::STATUS_W-1:0] fin_err;

   logic                         rsp_valid_ff;
   logic [hrv_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                         rsp_method_ff;
   logic [hrv_pkg::DIGIT_W-1:0]  rsp_major_ff;
   logic [hrv_pkg::DIGIT_W-1:0]  rsp_minor_ff;
   logic                         rsp_host_ff;
   logic [hrv_pkg::HEADER_W-1:0] rsp_count_ff;

   logic       is_key;
   logic       d0_hit;
   logic       d1_hit;
   logic [7:0] d0_char;
   logic       d0_legal;
   field_type  fld;
   logic [2:0] lit_len;
   logic       pop_last;

   assign item_pop = item_valid && (!item.last || !rsp_valid_ff || rsp_ready);
   assign pop_last = item_pop && item.last;

   always_comb begin
      phase_in   = phase_ff;
      lit_idx_in = lit_idx_ff;
      method_in  = method_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      dpend_in   = dpend_ff;
      illegal_in = illegal_ff;
      hmatch_in  = hmatch_ff;
      host_in    = host_ff;
      lines_in   = lines_ff;
      err_in     = err_ff;
      is_key     = (phase_ff == PH_KEY);
      d0_hit     = is_key ? item.colon : item.cr;
      d1_hit     = is_key ? item.space : item.lf;
      d0_char    = is_key ? 8'h3A : 8'h0D;
      d0_legal   = is_key;
      fld.ill    = illegal_ff;
      fld.hm     = hmatch_ff;
      lit_len    = method_ff ? 3'd5 : 3'd4;

      if (err_ff == hrv_pkg::ST_OK) begin
         case (phase_ff)
            PH_METHOD: begin
               if (lit_idx_ff == 3'd0) begin
                  if (item.data == 8'h47) begin
                     method_in  = 1'b0;
                     lit_idx_in = 3'd1;
                  end else if (item.data == 8'h50) begin
                     method_in  = 1'b1;
                     lit_idx_in = 3'd1;
                  end else begin
                     err_in = hrv_pkg::ST_METHOD;
                  end
               end else if (lit_idx_ff >= lit_len ||
                            item.data != method_char(method_ff, lit_idx_ff)) begin
                  err_in = hrv_pkg::ST_LITERAL;
               end else if (lit_idx_ff + 3'd1 == lit_len) begin
                  lit_idx_in = 3'd0;
                  phase_in   = PH_RES;
               end else begin
                  lit_idx_in = lit_idx_ff + 3'd1;
               end
            end
            PH_RES: begin
               if (item.space) begin
                  if (illegal_ff) begin
                     err_in = hrv_pkg::ST_ILLEGAL;
                  end else begin
                     phase_in = PH_HTTP;
                  end
               end else if (!item.legal) begin
                  illegal_in = 1'b1;
               end
            end
            PH_HTTP: begin
               if (lit_idx_ff >= 3'd5 || item.data != http_char(lit_idx_ff)) begin
                  err_in = hrv_pkg::ST_LITERAL;
               end else if (lit_idx_ff == 3'd4) begin
                  lit_idx_in = 3'd0;
                  phase_in   = PH_MAJ;
               end else begin
                  lit_idx_in = lit_idx_ff + 3'd1;
               end
            end
            PH_MAJ: begin
               if (!item.digit) begin
                  err_in = hrv_pkg::ST_DIGIT;
               end else begin
                  major_in = item.data[3:0];
                  phase_in = PH_DOT;
               end
            end
            PH_DOT: begin
               if (item.data == 8'h2E) begin
                  phase_in = PH_MIN;
               end else begin
                  err_in = hrv_pkg::ST_LITERAL;
               end
            end
            PH_MIN: begin
               if (!item.digit) begin
                  err_in = hrv_pkg::ST_DIGIT;
               end else begin
                  minor_in   = item.data[3:0];
                  phase_in   = PH_CRLF;
                  lit_idx_in = 3'd0;
               end
            end
            PH_CRLF: begin
               if (lit_idx_ff == 3'd0 && item.cr) begin
                  lit_idx_in = 3'd1;
               end else if (lit_idx_ff == 3'd1 && item.lf) begin
                  lit_idx_in = 3'd0;
                  phase_in   = PH_KEY;
                  illegal_in = 1'b0;
               end else begin
                  err_in = hrv_pkg::ST_LITERAL;
               end
            end
            PH_KEY, PH_VAL: begin
               if (dpend_ff && d1_hit) begin
                  dpend_in = 1'b0;
                  if (illegal_ff) begin
                     err_in = hrv_pkg::ST_ILLEGAL;
                  end else if (is_key) begin
                     phase_in = PH_VAL;
                  end else begin
                     if (lines_ff != '1) begin
                        lines_in = lines_ff + 1'b1;
                     end
                     if (hmatch_ff == HOST_HIT) begin
                        host_in = 1'b1;
                     end
                     hmatch_in = 3'd0;
                     phase_in  = PH_KEY;
                  end
               end else begin
                  // a held ':' or CR that was not a delimiter counts as field data
                  if (dpend_ff) begin
                     fld = field_step(fld, is_key, d0_char, d0_legal);
                  end
                  if (d0_hit) begin
                     dpend_in = 1'b1;
                  end else begin
                     dpend_in = 1'b0;
                     fld = field_step(fld, is_key, item.data, item.legal);
                  end
                  illegal_in = fld.ill;
                  hmatch_in  = fld.hm;
               end
            end
            default: begin
               err_in = hrv_pkg::ST_LITERAL;
            end
         endcase
      end
   end

   // status at end of request
   always_comb begin
      fin_err = err_in;
      if (err_in == hrv_pkg::ST_OK) begin
         case (phase_in)
            PH_METHOD, PH_HTTP, PH_DOT, PH_CRLF: fin_err = hrv_pkg::ST_LITERAL;
            PH_MAJ, PH_MIN:                      fin_err = hrv_pkg::ST_DIGIT;
            PH_KEY: begin
               if (hmatch_in != 3'd0 || dpend_in) begin
                  fin_err = hrv_pkg::ST_DELIM;
               end
            end
            default: fin_err = hrv_pkg::ST_DELIM;
         endcase
         if (fin_err == hrv_pkg::ST_OK && major_in == 4'd1 && minor_in == 4'd1 && !host_in) begin
            fin_err = hrv_pkg::ST_HOST;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || pop_last) begin
         phase_ff   <= PH_METHOD;
         lit_idx_ff <= '0;
         method_ff  <= 1'b0;
         major_ff   <= '0;
         minor_ff   <= '0;
         dpend_ff   <= 1'b0;
         illegal_ff <= 1'b0;
         hmatch_ff  <= '0;
         host_ff    <= 1'b0;
         lines_ff   <= '0;
         err_ff     <= hrv_pkg::ST_OK;
      end else if (item_pop) begin
         phase_ff   <= phase_in;
         lit_idx_ff <= lit_idx_in;
         method_ff  <= method_in;
         major_ff   <= major_in;
         minor_ff   <= minor_in;
         dpend_ff   <= dpend_in;
         illegal_ff <= illegal_in;
         hmatch_ff  <= hmatch_in;
         host_ff    <= host_in;
         lines_ff   <= lines_in;
         err_ff     <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_last) begin
         rsp_status_ff <= fin_err;
         rsp_method_ff <= method_in;
         rsp_major_ff  <= major_in;
         rsp_minor_ff  <= minor_in;
         rsp_host_ff   <= host_in;
         rsp_count_ff  <= hrv_pkg::HEADER_W'(lines_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_method_post   = rsp_method_ff;
   assign rsp_major_version = rsp_major_ff;
   assign rsp_minor_version = rsp_minor_ff;
   assign rsp_host_present  = rsp_host_ff;
   assign rsp_header_count  = rsp_count_ff;

`ifndef SYNTHESIS
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != hrv_pkg::ST_OK && !pop_last) |=> (err_ff == $past(err_ff)))
      else $error("parser error code changed before end of request");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      pop_last |=> (phase_ff == PH_METHOD && lines_ff == '0 && err_ff == hrv_pkg::ST_OK))
      else $error("parser state not cleared after last byte");

   a_host_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == hrv_pkg::ST_HOST) |->
      (rsp_major_ff == 4'd1 && rsp_minor_ff == 4'd1 && !rsp_host_ff))
      else $error("host required status without version 1.1 and missing Host");

   a_no_pop_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !pop_last)
      else $error("result overwritten while still pending");
`endif

endmodule

FILE: hdl/http_request_validator.sv
// Top level of the HTTP request validator: front classifier, item queue, parser back end.
// Depends on hrv_pkg, hrv_front, hrv_queue and hrv_back.
//
// Takes one request byte per cycle while req_ready is high, with req_last marking the
// final byte, and returns one result per request: status, method, version digits, Host
// flag and header count. Sustained rate is one byte per clock while nothing stalls; the
// parser state machine in the back end retires one byte per cycle except on a stalled
// last byte. A four-entry queue sits between the classifier and the parser, so input
// keeps flowing while a result waits in the output register. The last byte passes the
// queue and the parser into the registered rsp_ outputs; the back end only stalls on a
// last byte while the previous result has not been taken.
module http_request_validator #(
   parameter int COUNT_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [hrv_pkg::BYTE_W-1:0]    req_in_byte,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hrv_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_method_post,
   output logic [hrv_pkg::DIGIT_W-1:0]   rsp_major_version,
   output logic [hrv_pkg::DIGIT_W-1:0]   rsp_minor_version,
   output logic                          rsp_host_present,
   output logic [hrv_pkg::HEADER_W-1:0]  rsp_header_count
);

   hrv_pkg::item_type front_item;
   hrv_pkg::item_type queue_item;
   logic              queue_valid;
   logic              queue_pop;

   hrv_front u_front (
      .in_byte (req_in_byte),
      .in_last (req_last),
      .item    (front_item)
   );

   hrv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop        (queue_pop),
      .pop_item   (queue_item)
   );

   hrv_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (queue_valid),
      .item              (queue_item),
      .item_pop          (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_method_post   (rsp_method_post),
      .rsp_major_version (rsp_major_version),
      .rsp_minor_version (rsp_minor_version),
      .rsp_host_present  (rsp_host_present),
      .rsp_header_count  (rsp_header_count)
   );

endmodule
